[design/script_lexer_defines.svh]
// Assertion macros shared by the lexer RTL files.
`ifndef SCRIPT_LEXER_DEFINES_SVH
`define SCRIPT_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
`define SL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SL_ASSERT(lbl, prop, msg)
`define SL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[design/sl_pkg.sv]
// Types and constants shared by the script lexer modules.
`default_nettype none

package sl_pkg;

  // Token kinds as seen on the result port
  typedef enum logic [4:0] {
    K_COLON    = 5'd0,
    K_SEMI     = 5'd1,
    K_LPAREN   = 5'd2,
    K_RPAREN   = 5'd3,
    K_LCURLY   = 5'd4,
    K_RCURLY   = 5'd5,
    K_COMMA    = 5'd6,
    K_PLUS     = 5'd7,
    K_MINUS    = 5'd8,
    K_ARROW    = 5'd9,
    K_STAR     = 5'd10,
    K_ASSIGN   = 5'd11,
    K_EQUALITY = 5'd12,
    K_NUMBER   = 5'd13,
    K_RETURN   = 5'd14,
    K_IF       = 5'd15,
    K_I32      = 5'd16,
    K_MUT      = 5'd17,
    K_IDENT    = 5'd18,
    K_ERROR    = 5'd19,
    K_END      = 5'd20
  } kind_t;

  // Byte classes produced by the front end
  typedef enum logic [3:0] {
    CL_SPACE,
    CL_LF,
    CL_TAB,
    CL_PUNCT,
    CL_MINUS,
    CL_EQ,
    CL_GT,
    CL_DOT,
    CL_DIGIT,
    CL_ALPHA,
    CL_OTHER
  } cls_t;

  // Classified byte handed from front end to engine
  typedef struct packed {
    cls_t        cls;
    kind_t       punct_kind;
    logic [7:0]  ch;
    logic        eos;
  } front_item_t;

  // Position-independent part of a token record
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  len;
    logic        sat;
    logic [7:0]  bad;
  } tok_info_t;

  // Keyword prefixes, packed first character highest
  localparam logic [47:0] KW_RETURN = 48'h72657475726E;
  localparam logic [47:0] KW_IF     = 48'h000000006966;
  localparam logic [47:0] KW_I32    = 48'h000000693332;
  localparam logic [47:0] KW_MUT    = 48'h0000006D7574;
  localparam int unsigned PFX_CHARS = 6;

endpackage

`default_nettype wire

[design/sl_fifo.sv]
// Small register-based queue used between the lexer stages.
`default_nettype none
`include "script_lexer_defines.svh"

module sl_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  // status and head word
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `SL_ASSERT_ALWAYS(a_fifo_reset_empty, !rst_n |=> cnt_r == '0, "queue not empty after reset")
  `SL_ASSERT(a_fifo_bound, cnt_r <= (AW+1)'(DEPTH), "queue occupancy beyond depth")

endmodule

`default_nettype wire

[design/sl_front.sv]
// Front end: accepts script bytes and classifies them for the engine.
`default_nettype none

module sl_front (
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         in_char_byte,
  input  wire logic               in_end_of_script,
  input  wire logic               q_full,
  output logic                    q_wr,
  output sl_pkg::front_item_t     q_item
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_UPPERZ = 8'h5A;
  localparam logic [7:0] CH_LOWERA = 8'h61;
  localparam logic [7:0] CH_LOWERZ = 8'h7A;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  logic is_digit, is_alpha;

  // accept a word while the queue has room
  assign full = q_full;
  assign q_wr = push && !q_full;

  assign is_digit = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign is_alpha = ((in_char_byte >= CH_UPPERA) && (in_char_byte <= CH_UPPERZ)) ||
                    ((in_char_byte >= CH_LOWERA) && (in_char_byte <= CH_LOWERZ));

  // classify the byte
  always_comb begin
    q_item.ch         = in_char_byte;
    q_item.eos        = in_end_of_script;
    q_item.punct_kind = sl_pkg::K_COLON;
    q_item.cls        = sl_pkg::CL_OTHER;
    if (is_digit) begin
      q_item.cls = sl_pkg::CL_DIGIT;
    end else if (is_alpha) begin
      q_item.cls = sl_pkg::CL_ALPHA;
    end else begin
      unique case (in_char_byte)
        CH_SPACE, CH_CR: q_item.cls = sl_pkg::CL_SPACE;
        CH_LF:           q_item.cls = sl_pkg::CL_LF;
        CH_TAB:          q_item.cls = sl_pkg::CL_TAB;
        CH_MINUS:        q_item.cls = sl_pkg::CL_MINUS;
        CH_EQ:           q_item.cls = sl_pkg::CL_EQ;
        CH_GT:           q_item.cls = sl_pkg::CL_GT;
        CH_DOT:          q_item.cls = sl_pkg::CL_DOT;
        CH_COLON: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_COLON;
        end
        CH_SEMI: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_SEMI;
        end
        CH_LPAREN: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_LPAREN;
        end
        CH_RPAREN: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_RPAREN;
        end
        CH_LCURLY: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_LCURLY;
        end
        CH_RCURLY: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_RCURLY;
        end
        CH_COMMA: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_COMMA;
        end
        CH_PLUS: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_PLUS;
        end
        CH_STAR: begin
          q_item.cls        = sl_pkg::CL_PUNCT;
          q_item.punct_kind = sl_pkg::K_STAR;
        end
        default: q_item.cls = sl_pkg::CL_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/sl_engine.sv]
// Back end: lexer state machine building up to three token records per byte.
`default_nettype none
`include "script_lexer_defines.svh"

module sl_engine #(
  parameter int MAXL = 255,
  parameter int PW   = 16,
  parameter int BW   = 2 + 3 * ($bits(sl_pkg::tok_info_t) + 2 * PW)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [3:0]           cfg_wr_data,
  input  wire logic                 in_valid,
  input  wire sl_pkg::front_item_t  in_item,
  output logic                      in_take,
  input  wire logic                 bnd_full,
  output logic                      bnd_wr,
  output logic [BW-1:0]             bnd_data
);

  localparam int LW = $clog2(MAXL + 2);

  typedef enum logic [2:0] {
    M_IDLE,
    M_MINUS,
    M_EQ,
    M_NUM,
    M_WORD,
    M_ERR
  } mode_t;

  typedef struct packed {
    sl_pkg::tok_info_t info;
    logic [PW-1:0]     line;
    logic [PW-1:0]     col;
  } rec_t;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] line_r, line_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [47:0]   pfx_r, pfx_nxt;
  logic [3:0]    tab_r;

  logic [PW:0]   sum_one, sum_tab;
  logic [PW-1:0] col_inc, col_tab, line_inc;
  rec_t          recs [3];
  logic [1:0]    n;
  logic          used;
  logic          run_grow;

  // token info with no length saturation
  function automatic sl_pkg::tok_info_t mk(input sl_pkg::kind_t k, input logic [7:0] l,
                                           input logic [7:0] b);
    sl_pkg::tok_info_t t;
    t.kind = k;
    t.len  = l;
    t.sat  = 1'b0;
    t.bad  = b;
    return t;
  endfunction

  // pending token of a mode, with keyword lookup for words
  function automatic sl_pkg::tok_info_t flush_info(input mode_t m, input logic [LW-1:0] len,
                                                   input logic [47:0] pfx);
    sl_pkg::tok_info_t t;
    logic [LW-1:0]     shown;
    logic [31:0]       shown32;
    shown   = (len > LW'(MAXL)) ? LW'(MAXL) : len;
    shown32 = 32'(shown);
    t.kind  = sl_pkg::K_IDENT;
    t.len   = shown32[7:0];
    t.sat   = (len > LW'(MAXL));
    t.bad   = 8'd0;
    unique case (m)
      M_MINUS: t = mk(sl_pkg::K_MINUS, 8'd1, 8'd0);
      M_EQ:    t = mk(sl_pkg::K_ASSIGN, 8'd1, 8'd0);
      M_NUM:   t.kind = sl_pkg::K_NUMBER;
      M_WORD: begin
        if (len == LW'(6) && pfx == sl_pkg::KW_RETURN) begin
          t.kind = sl_pkg::K_RETURN;
        end else if (len == LW'(2) && pfx == sl_pkg::KW_IF) begin
          t.kind = sl_pkg::K_IF;
        end else if (len == LW'(3) && pfx == sl_pkg::KW_I32) begin
          t.kind = sl_pkg::K_I32;
        end else if (len == LW'(3) && pfx == sl_pkg::KW_MUT) begin
          t.kind = sl_pkg::K_MUT;
        end
      end
      default: t.kind = sl_pkg::K_IDENT;
    endcase
    return t;
  endfunction

  function automatic logic has_pending(input mode_t m);
    return (m == M_MINUS) || (m == M_EQ) || (m == M_NUM) || (m == M_WORD);
  endfunction

  // take a byte whenever the result queue has room
  assign in_take = in_valid && !bnd_full;

  // saturating position arithmetic
  assign sum_one  = {1'b0, col_r} + (PW+1)'(1);
  assign sum_tab  = {1'b0, col_r} + (PW+1)'(tab_r) + (PW+1)'(1);
  assign col_inc  = sum_one[PW] ? {PW{1'b1}} : sum_one[PW-1:0];
  assign col_tab  = sum_tab[PW] ? {PW{1'b1}} : sum_tab[PW-1:0];
  assign line_inc = (&line_r) ? line_r : line_r + PW'(1);

  assign run_grow =
    ((mode_r == M_NUM) && ((in_item.cls == sl_pkg::CL_DIGIT) ||
                           (in_item.cls == sl_pkg::CL_DOT))) ||
    ((mode_r == M_WORD) && ((in_item.cls == sl_pkg::CL_DIGIT) ||
                            (in_item.cls == sl_pkg::CL_ALPHA)));

  // next lexer state and the records this byte produces
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    len_nxt  = len_r;
    pfx_nxt  = pfx_r;
    used     = 1'b0;
    n        = 2'd0;
    for (int i = 0; i < 3; i++) begin
      recs[i] = '0;
    end
    if (in_take) begin
      if (mode_r == M_ERR) begin
        // drop bytes until the script ends
        if (in_item.eos) begin
          mode_nxt = M_IDLE;
          line_nxt = '0;
          col_nxt  = '0;
          len_nxt  = '0;
          pfx_nxt  = '0;
        end
      end else begin
        if (mode_r == M_MINUS && in_item.cls == sl_pkg::CL_GT) begin
          recs[n] = '{info: mk(sl_pkg::K_ARROW, 8'd2, 8'd0), line: line_r, col: col_r};
          n        = n + 2'd1;
          mode_nxt = M_IDLE;
          col_nxt  = col_inc;
          used     = 1'b1;
        end else if (mode_r == M_EQ && in_item.cls == sl_pkg::CL_EQ) begin
          recs[n] = '{info: mk(sl_pkg::K_EQUALITY, 8'd2, 8'd0), line: line_r, col: col_r};
          n        = n + 2'd1;
          mode_nxt = M_IDLE;
          col_nxt  = col_inc;
          used     = 1'b1;
        end else if (run_grow) begin
          if (len_r < LW'(sl_pkg::PFX_CHARS)) begin
            pfx_nxt = {pfx_r[39:0], in_item.ch};
          end
          if (len_r <= LW'(MAXL)) begin
            len_nxt = len_r + LW'(1);
          end
          col_nxt = col_inc;
          used    = 1'b1;
        end else begin
          // flush whatever was pending
          if (has_pending(mode_r)) begin
            recs[n] = '{info: flush_info(mode_r, len_r, pfx_r), line: line_r, col: col_r};
            n       = n + 2'd1;
          end
          mode_nxt = M_IDLE;
          len_nxt  = '0;
          pfx_nxt  = '0;
        end

        if (!used) begin
          col_nxt = col_inc;
          unique case (in_item.cls)
            sl_pkg::CL_SPACE: col_nxt = col_inc;
            sl_pkg::CL_LF: begin
              line_nxt = line_inc;
              col_nxt  = '0;
            end
            sl_pkg::CL_TAB:   col_nxt = col_tab;
            sl_pkg::CL_PUNCT: begin
              recs[n] = '{info: mk(in_item.punct_kind, 8'd1, 8'd0), line: line_r, col: col_inc};
              n       = n + 2'd1;
            end
            sl_pkg::CL_MINUS: mode_nxt = M_MINUS;
            sl_pkg::CL_EQ:    mode_nxt = M_EQ;
            sl_pkg::CL_DIGIT: begin
              mode_nxt = M_NUM;
              len_nxt  = LW'(1);
              pfx_nxt  = {40'd0, in_item.ch};
            end
            sl_pkg::CL_ALPHA: begin
              mode_nxt = M_WORD;
              len_nxt  = LW'(1);
              pfx_nxt  = {40'd0, in_item.ch};
            end
            default: begin
              recs[n]  = '{info: mk(sl_pkg::K_ERROR, 8'd1, in_item.ch), line: line_r,
                           col: col_inc};
              n        = n + 2'd1;
              mode_nxt = M_ERR;
            end
          endcase
        end

        // end of script: unless in error, flush and mark the end; always clear the stream
        if (in_item.eos) begin
          if (mode_nxt != M_ERR) begin
            if (has_pending(mode_nxt)) begin
              recs[n] = '{info: flush_info(mode_nxt, len_nxt, pfx_nxt), line: line_nxt,
                          col: col_nxt};
              n       = n + 2'd1;
            end
            recs[n] = '{info: mk(sl_pkg::K_END, 8'd0, 8'd0), line: line_nxt, col: col_nxt};
            n       = n + 2'd1;
          end
          mode_nxt = M_IDLE;
          line_nxt = '0;
          col_nxt  = '0;
          len_nxt  = '0;
          pfx_nxt  = '0;
        end
      end
    end
  end

  // push a bundle only when the byte produced records
  assign bnd_wr   = in_take && (n != 2'd0);
  assign bnd_data = {n, recs[2], recs[1], recs[0]};

  // hold lexer state and the tab register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= '0;
      col_r  <= '0;
      len_r  <= '0;
      pfx_r  <= '0;
      tab_r  <= 4'd4;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      len_r  <= len_nxt;
      pfx_r  <= pfx_nxt;
      if (cfg_wr_en) begin
        tab_r <= cfg_wr_data;
      end
    end
  end

  `SL_ASSERT(a_err_silent, (in_take && mode_r == M_ERR) |-> !bnd_wr, "records after an error")
  `SL_ASSERT(a_eos_clr, (in_take && in_item.eos) |=> mode_r == M_IDLE && col_r == '0, "no clear")

endmodule

`default_nettype wire

[design/sl_serial.sv]
// Output stage: hands out the records of each bundle one word at a time.
`default_nettype none
`include "script_lexer_defines.svh"

module sl_serial #(
  parameter int PW = 16,
  parameter int BW = 2 + 3 * ($bits(sl_pkg::tok_info_t) + 2 * PW)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [BW-1:0]  bnd_data,
  input  wire logic           bnd_empty,
  output logic                bnd_rd,
  output logic                empty,
  input  wire logic           pop,
  output logic [4:0]          out_token_kind,
  output logic [PW-1:0]       out_token_line,
  output logic [PW-1:0]       out_token_column,
  output logic [7:0]          out_lexeme_length,
  output logic                out_length_saturated,
  output logic [7:0]          out_bad_char,
  output logic                out_last_of_run
);

  localparam int RW = $bits(sl_pkg::tok_info_t) + 2 * PW;

  typedef struct packed {
    sl_pkg::tok_info_t info;
    logic [PW-1:0]     line;
    logic [PW-1:0]     col;
  } rec_t;

  rec_t       recs [3];
  rec_t       cur;
  logic [1:0] cnt;
  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       do_pop;

  // unpack the head bundle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recs[i] = bnd_data[i*RW +: RW];
    end
  end

  assign cnt    = bnd_data[BW-1 -: 2];
  assign cur    = recs[idx_r];
  assign last   = (idx_r == cnt - 2'd1);
  assign empty  = bnd_empty;
  assign do_pop = pop && !bnd_empty;
  assign bnd_rd = do_pop && last;

  // drive the current record
  assign out_token_kind       = cur.info.kind;
  assign out_token_line       = cur.line;
  assign out_token_column     = cur.col;
  assign out_lexeme_length    = cur.info.len;
  assign out_length_saturated = cur.info.sat;
  assign out_bad_char         = cur.info.bad;
  assign out_last_of_run      = last;

  // advance through the bundle
  always_comb begin
    idx_nxt = idx_r;
    if (do_pop) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `SL_ASSERT(a_idx_in_bundle, !bnd_empty |-> (cnt != 2'd0 && idx_r < cnt), "index off bundle")

endmodule

`default_nettype wire

[design/script_lexer.sv]
// Script lexer top level: one byte accepted per cycle while full is low, token records
// out of a queue. A taken byte is registered in the middle queue; the engine then
// writes its bundle into the bundle queue. The output side moves one record per cycle
// while pop is held, so a byte giving k records takes k pops; the queues absorb bursts.
// Reset (rst_n low, synchronous) empties both queues, clears the lexer state and sets
// tab_extra_columns to 4; no clearing pass is needed.
`default_nettype none

module script_lexer #(
  parameter int MAX_LEXEME_LENGTH = 255,
  parameter int POSITION_WIDTH    = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [3:0]                 cfg_wr_data,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [7:0]                 in_char_byte,
  input  wire logic                       in_end_of_script,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [4:0]                      out_token_kind,
  output logic [POSITION_WIDTH-1:0]       out_token_line,
  output logic [POSITION_WIDTH-1:0]       out_token_column,
  output logic [7:0]                      out_lexeme_length,
  output logic                            out_length_saturated,
  output logic [7:0]                      out_bad_char,
  output logic                            out_last_of_run
);

  localparam int FW = $bits(sl_pkg::front_item_t);
  localparam int RW = $bits(sl_pkg::tok_info_t) + 2 * POSITION_WIDTH;
  localparam int BW = 2 + 3 * RW;

  sl_pkg::front_item_t front_item;
  sl_pkg::front_item_t eng_item;
  logic [FW-1:0]       mid_rd_data;
  logic                mid_wr, mid_full, mid_rd, mid_empty;
  logic                bnd_wr, bnd_full, bnd_rd, bnd_empty;
  logic [BW-1:0]       bnd_wr_data, bnd_rd_data;

  // classify incoming bytes
  sl_front u_front (
    .push             (push),
    .full             (full),
    .in_char_byte     (in_char_byte),
    .in_end_of_script (in_end_of_script),
    .q_full           (mid_full),
    .q_wr             (mid_wr),
    .q_item           (front_item)
  );

  // queue between front end and engine
  sl_fifo #(.W(FW), .DEPTH(4)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (front_item),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_data),
    .empty   (mid_empty)
  );

  assign eng_item = mid_rd_data;

  // lexer engine
  sl_engine #(.MAXL(MAX_LEXEME_LENGTH), .PW(POSITION_WIDTH), .BW(BW)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (!mid_empty),
    .in_item     (eng_item),
    .in_take     (mid_rd),
    .bnd_full    (bnd_full),
    .bnd_wr      (bnd_wr),
    .bnd_data    (bnd_wr_data)
  );

  // queue of record bundles
  sl_fifo #(.W(BW), .DEPTH(4)) u_bnd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bnd_wr),
    .wr_data (bnd_wr_data),
    .full    (bnd_full),
    .rd_en   (bnd_rd),
    .rd_data (bnd_rd_data),
    .empty   (bnd_empty)
  );

  // hand out records one word at a time
  sl_serial #(.PW(POSITION_WIDTH), .BW(BW)) u_serial (
    .clk                  (clk),
    .rst_n                (rst_n),
    .bnd_data             (bnd_rd_data),
    .bnd_empty            (bnd_empty),
    .bnd_rd               (bnd_rd),
    .empty                (empty),
    .pop                  (pop),
    .out_token_kind       (out_token_kind),
    .out_token_line       (out_token_line),
    .out_token_column     (out_token_column),
    .out_lexeme_length    (out_lexeme_length),
    .out_length_saturated (out_length_saturated),
    .out_bad_char         (out_bad_char),
    .out_last_of_run      (out_last_of_run)
  );

endmodule

`default_nettype wire

[verif/tb_script_lexer.sv]
// Self-checking testbench for script_lexer: drives byte scripts and checks every token word.
`default_nettype none

module tb_script_lexer;

  localparam int MAX_LEN      = 255;
  localparam int POS_MAX      = 65535;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  localparam logic [47:0] WORD_RETURN = "return";
  localparam logic [47:0] WORD_IF     = "if";
  localparam logic [47:0] WORD_I32    = "i32";
  localparam logic [47:0] WORD_MUT    = "mut";

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_MINUS, SCAN_EQ, SCAN_NUM, SCAN_WORD, SCAN_ERR
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } script_byte_t;

  typedef struct packed {
    sl_pkg::kind_t kind;
    logic [15:0]   tok_line;
    logic [15:0]   tok_col;
    logic [7:0]    lex_len;
    logic          len_sat;
    logic [7:0]    bad;
    logic          last;
  } token_rec_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        cfg_wr_en        = 1'b0;
  logic [3:0]  cfg_wr_data      = 4'd0;
  logic        push             = 1'b0;
  logic        full;
  logic [7:0]  in_char_byte     = 8'd0;
  logic        in_end_of_script = 1'b0;
  logic        empty;
  logic        pop              = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_line;
  logic [15:0] out_token_column;
  logic [7:0]  out_lexeme_length;
  logic        out_length_saturated;
  logic [7:0]  out_bad_char;
  logic        out_last_of_run;

  script_lexer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .push                 (push),
    .full                 (full),
    .in_char_byte         (in_char_byte),
    .in_end_of_script     (in_end_of_script),
    .empty                (empty),
    .pop                  (pop),
    .out_token_kind       (out_token_kind),
    .out_token_line       (out_token_line),
    .out_token_column     (out_token_column),
    .out_lexeme_length    (out_lexeme_length),
    .out_length_saturated (out_length_saturated),
    .out_bad_char         (out_bad_char),
    .out_last_of_run      (out_last_of_run)
  );

  // Byte words waiting to be offered, token words waiting to be seen
  script_byte_t script_bytes[$];
  token_rec_t   expected_tokens[$];
  logic [7:0]   draft[$];

  // Lexer state as the stream sees it
  scan_mode_t  mode     = SCAN_IDLE;
  logic [15:0] line_no  = '0;
  logic [15:0] col_no   = '0;
  int          run_len  = 0;
  logic [47:0] prefix   = '0;
  logic [3:0]  tab_extra = 4'd4;

  bit          calm          = 1'b0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          send_gap      = 0;
  int          recv_gap      = 0;
  int          fail_count    = 0;
  int          tokens_checked = 0;
  int          bytes_taken   = 0;
  int          scripts_sent  = 0;
  int          cycle_count   = 0;
  logic [3:0]  mid_tab       = 4'd0;

  string keyword_list[4] = '{"return", "if", "i32", "mut"};
  string punct_set = ":;(){},+*";

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d token words outstanding", cycle_count,
               expected_tokens.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  // Mostly short gaps, now and then a long one; none in a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic emit_token(input sl_pkg::kind_t kind, input int len, input logic [7:0] bad);
    token_rec_t rec;
    rec.kind     = kind;
    rec.tok_line = line_no;
    rec.tok_col  = col_no;
    rec.lex_len  = (len > MAX_LEN) ? 8'(MAX_LEN) : 8'(len);
    rec.len_sat  = (len > MAX_LEN);
    rec.bad      = bad;
    rec.last     = 1'b0;
    expected_tokens = {expected_tokens, rec};
  endtask

  task automatic col_advance(input int k);
    int v;
    v = int'(col_no) + k;
    col_no = (v > POS_MAX) ? 16'(POS_MAX) : 16'(v);
  endtask

  task automatic grow_run(input logic [7:0] ch);
    if (run_len < 6) prefix = {prefix[39:0], ch};
    if (run_len <= MAX_LEN) run_len++;
  endtask

  task automatic restart_script();
    mode    = SCAN_IDLE;
    line_no = '0;
    col_no  = '0;
    run_len = 0;
    prefix  = '0;
  endtask

  // Emit whatever token is still open, then go idle
  task automatic flush_pending();
    sl_pkg::kind_t kind;
    kind = sl_pkg::K_IDENT;
    case (mode)
      SCAN_MINUS: emit_token(sl_pkg::K_MINUS, 1, 8'h00);
      SCAN_EQ:    emit_token(sl_pkg::K_ASSIGN, 1, 8'h00);
      SCAN_NUM:   emit_token(sl_pkg::K_NUMBER, run_len, 8'h00);
      SCAN_WORD: begin
        if (run_len == 6 && prefix == WORD_RETURN) kind = sl_pkg::K_RETURN;
        else if (run_len == 2 && prefix == WORD_IF) kind = sl_pkg::K_IF;
        else if (run_len == 3 && prefix == WORD_I32) kind = sl_pkg::K_I32;
        else if (run_len == 3 && prefix == WORD_MUT) kind = sl_pkg::K_MUT;
        emit_token(kind, run_len, 8'h00);
      end
      default: ;
    endcase
    mode    = SCAN_IDLE;
    run_len = 0;
    prefix  = '0;
  endtask

  // Work out the token words that one accepted byte causes
  task automatic lex_byte(input logic [7:0] ch, input logic eos);
    int         first;
    bit         taken;
    token_rec_t rec;
    first = expected_tokens.size();
    taken = 1'b0;
    if (mode == SCAN_ERR) begin
      if (eos) restart_script();
    end else begin
      if (mode == SCAN_MINUS && ch == CH_GT) begin
        emit_token(sl_pkg::K_ARROW, 2, 8'h00);
        mode = SCAN_IDLE;
        col_advance(1);
        taken = 1'b1;
      end else if (mode == SCAN_EQ && ch == CH_EQ) begin
        emit_token(sl_pkg::K_EQUALITY, 2, 8'h00);
        mode = SCAN_IDLE;
        col_advance(1);
        taken = 1'b1;
      end else if ((mode == SCAN_NUM && (is_digit(ch) || ch == CH_DOT)) ||
                   (mode == SCAN_WORD && (is_digit(ch) || is_alpha(ch)))) begin
        grow_run(ch);
        col_advance(1);
        taken = 1'b1;
      end else begin
        flush_pending();
      end

      if (!taken) begin
        col_advance(1);
        case (ch)
          CH_SPACE, CH_CR: ;
          CH_LF: begin
            if (line_no != 16'(POS_MAX)) line_no++;
            col_no = '0;
          end
          CH_TAB:  col_advance(int'(tab_extra));
          ":":     emit_token(sl_pkg::K_COLON, 1, 8'h00);
          ";":     emit_token(sl_pkg::K_SEMI, 1, 8'h00);
          "(":     emit_token(sl_pkg::K_LPAREN, 1, 8'h00);
          ")":     emit_token(sl_pkg::K_RPAREN, 1, 8'h00);
          "{":     emit_token(sl_pkg::K_LCURLY, 1, 8'h00);
          "}":     emit_token(sl_pkg::K_RCURLY, 1, 8'h00);
          ",":     emit_token(sl_pkg::K_COMMA, 1, 8'h00);
          "+":     emit_token(sl_pkg::K_PLUS, 1, 8'h00);
          "*":     emit_token(sl_pkg::K_STAR, 1, 8'h00);
          CH_DASH: mode = SCAN_MINUS;
          CH_EQ:   mode = SCAN_EQ;
          default: begin
            if (is_digit(ch) || is_alpha(ch)) begin
              mode    = is_digit(ch) ? SCAN_NUM : SCAN_WORD;
              run_len = 0;
              prefix  = '0;
              grow_run(ch);
            end else begin
              emit_token(sl_pkg::K_ERROR, 1, ch);
              mode = SCAN_ERR;
            end
          end
        endcase
      end

      // Final byte: close the open token and mark the end, unless in error
      if (eos) begin
        if (mode != SCAN_ERR) begin
          flush_pending();
          emit_token(sl_pkg::K_END, 0, 8'h00);
        end
        restart_script();
      end
    end

    if (expected_tokens.size() > first) begin
      rec = expected_tokens.pop_back();
      rec.last = 1'b1;
      expected_tokens = {expected_tokens, rec};
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch on token word %0d: %s got %0d expected %0d", tokens_checked, what,
             got, want);
  endtask

  // Sender: offer queued bytes, hold while full, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        lex_byte(in_char_byte, in_end_of_script);
        void'(script_bytes.pop_front());
        bytes_taken++;
        send_gap = pick_gap();
      end
      if (push && full) begin
        // hold the word until it is taken
      end else if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (script_bytes.size() != 0) begin
        push             <= 1'b1;
        in_char_byte     <= script_bytes[0].ch;
        in_end_of_script <= script_bytes[0].eos;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each popped word against the oldest prediction
  always @(posedge clk) begin
    token_rec_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("kind, with no word expected", out_token_kind, -1);
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind !== want.kind)
            report_mismatch("kind", out_token_kind, want.kind);
          if (out_token_line !== want.tok_line)
            report_mismatch("line", out_token_line, want.tok_line);
          if (out_token_column !== want.tok_col)
            report_mismatch("column", out_token_column, want.tok_col);
          if (out_lexeme_length !== want.lex_len)
            report_mismatch("length", out_lexeme_length, want.lex_len);
          if (out_length_saturated !== want.len_sat)
            report_mismatch("length_saturated", out_length_saturated, want.len_sat);
          if (out_bad_char !== want.bad)
            report_mismatch("bad_char", out_bad_char, want.bad);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
        end
        tokens_checked++;
        recv_gap = pick_gap();
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (recv_gap > 0) begin
        pop <= 1'b0;
        recv_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) draft = {draft, s[i]};
  endtask

  task automatic push_repeat(input logic [7:0] ch, input int n);
    repeat (n) draft = {draft, ch};
  endtask

  // Hand the draft over as one script, the last byte marked final
  task automatic queue_draft();
    script_byte_t sb;
    for (int i = 0; i < draft.size(); i++) begin
      sb.ch  = draft[i];
      sb.eos = (i == draft.size() - 1);
      script_bytes = {script_bytes, sb};
    end
    draft.delete();
    scripts_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // One well-formed piece of script with random content
  task automatic add_snippet();
    string kw;
    kw = keyword_list[$urandom_range(0, 3)];
    case ($urandom_range(0, 11))
      0: push_text(kw);
      1, 2: begin
        push_repeat(rand_letter(), 1);
        repeat ($urandom_range(0, 7))
          push_repeat(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1);
      end
      3: begin
        push_repeat(rand_digit(), 1);
        repeat ($urandom_range(0, 5))
          push_repeat(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit(), 1);
      end
      4, 11: push_repeat(punct_set[$urandom_range(0, 8)], 1);
      5: push_text("->");
      6: push_text("==");
      7: push_repeat(CH_EQ, 1);
      8: push_repeat(CH_DASH, 1);
      9: push_repeat(rand_space(), 1);
      default: begin
        // near misses of keywords
        if ($urandom_range(0, 1)) begin
          push_text(kw);
          push_repeat(($urandom_range(0, 1) == 0) ? rand_digit() : rand_letter(), 1);
        end else begin
          push_text(kw.substr(0, kw.len() - 2));
        end
      end
    endcase
  endtask

  // Random scripts, now and then with a stray byte dropped in
  task automatic add_random_scripts(input int target);
    int added;
    added = 0;
    while (added < target) begin
      repeat ($urandom_range(2, 6)) begin
        add_snippet();
        if ($urandom_range(0, 1)) push_repeat(rand_space(), 1);
      end
      if ($urandom_range(0, 5) == 0)
        draft.insert($urandom_range(0, draft.size()), 8'($urandom_range(0, 255)));
      added += draft.size();
      queue_draft();
    end
  endtask

  // Wait until everything offered is taken and every token word has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (script_bytes.size() != 0 || push || expected_tokens.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_tab_extra(input logic [3:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tab_extra = v;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed scripts at the reset tab width
    @(negedge clk);
    push_text("i32:-5");
    push_repeat(CH_TAB, 1);
    push_text("{x== y}");
    push_repeat(CH_CR, 1);
    queue_draft();
    push_text("mut=+*");
    push_repeat(CH_LF, 1);
    push_text("z");
    push_repeat(8'hFF, 1);
    push_repeat(8'h00, 1);
    push_repeat(8'h80, 1);
    push_text(",");
    queue_draft();
    push_text("->(7-=");
    queue_draft();
    push_repeat(CH_SPACE, 1);
    queue_draft();
    wait_idle();

    // Keyword near miss, number with dots and tabs at the widest tab
    set_tab_extra(4'd15);
    @(negedge clk);
    calm = 1'b1;
    push_text("returns");
    push_repeat(CH_TAB, 1);
    push_text("1.2");
    push_repeat(CH_TAB, 2);
    push_text(";if");
    queue_draft();
    wait_idle();

    // Random scripts with no tab width, behind a long output hold-off
    set_tab_extra(4'd0);
    @(negedge clk);
    calm = 1'b0;
    hold_requests++;
    repeat (12) push_repeat(punct_set[$urandom_range(0, 8)], 1);
    queue_draft();
    add_random_scripts(12);
    wait_idle();

    // Random scripts at a mid tab width
    mid_tab = 4'($urandom_range(1, 14));
    set_tab_extra(mid_tab);
    @(negedge clk);
    add_random_scripts(18);
    wait_idle();

    // Back-to-back stretch with no idling on either side
    @(negedge clk);
    calm = 1'b1;
    add_random_scripts(14);
    wait_idle();

    $display("covered %0d bytes in %0d scripts; %0d token words checked, %0d mismatches",
             bytes_taken, scripts_sent, tokens_checked, fail_count);
    $display("tab widths 4, 15, 0 and %0d; keywords, pairs, runs, stray bytes, output hold-off",
             mid_tab);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
